// ----- rtl/fir_pkg.sv -----
package fir_pkg;

	localparam int MAX_TAP_COUNT = 64;

	localparam int REQ_W    = 2;
	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = 6;
	localparam int COEF_W   = 32;
	localparam int TAP_W    = 7;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_COEF   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	localparam logic [TAP_W-1:0] TAP_COUNT_RST = 7'd64;

	// Q1.31 * Q1.15 -> Q2.46, result keeps 15 fraction bits
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int FRAC_SHIFT = 31;

	typedef struct packed {
		logic clr;     // zero the accumulator
		logic mul_en;  // product in stage 1 is a live term
	} mac_ctl_t;

endpackage

// ----- rtl/fir_req_if.sv -----
interface fir_req_if;
	logic                                valid;
	logic                                ready;
	logic [fir_pkg::REQ_W-1:0]           req_type;
	logic signed [fir_pkg::SAMPLE_W-1:0] sample_in;
	logic [fir_pkg::IDX_W-1:0]           coef_index;
	logic signed [fir_pkg::COEF_W-1:0]   coef_value;
	logic                                block_end;

	modport source (output valid, req_type, sample_in, coef_index, coef_value, block_end,
		input ready);
	modport sink (input valid, req_type, sample_in, coef_index, coef_value, block_end,
		output ready);
endinterface

// ----- rtl/fir_rsp_if.sv -----
interface fir_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [fir_pkg::SAMPLE_W-1:0] sample_out;
	logic                                block_end_out;

	modport source (output valid, sample_out, block_end_out, input ready);
	modport sink (input valid, sample_out, block_end_out, output ready);
endinterface

// ----- rtl/fir_filter_loadable_coefs.sv -----
// Channel  Dir  Payload                                                Transfer
// req_ch   in   req_type, sample_in, coef_index, coef_value, block_end valid & ready
// rsp_ch   out  sample_out, block_end_out                              valid & ready
// cfg      in   cfg_wdata (tap_count)                                  cfg_we
//
// A sample keeps ready low while the sequencer makes one pass per tap on the shared
// multiplier, n = active taps capped at MaxTaps (one pass when zero), drains the product
// and accumulator registers and loads the output register. Ready returns high as the
// result becomes valid. Coefficient and clear requests do not drop ready.
// Reset clears tap_count to 64 and all valid bits; no clearing sweep is needed.
// A waiting result does not block requests; a second finished result holds the sequencer.
module fir_filter_loadable_coefs #(
	parameter int MaxTaps = fir_pkg::MAX_TAP_COUNT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fir_pkg::TAP_W-1:0]  cfg_wdata,
	fir_req_if.sink                    req_ch,
	fir_rsp_if.source                  rsp_ch
);

	localparam int AddrW = $clog2(MaxTaps);
	localparam int CntW  = $clog2(MaxTaps + 1);
	localparam int CmpW  = (CntW > fir_pkg::TAP_W) ? CntW : fir_pkg::TAP_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [fir_pkg::TAP_W-1:0]  tap_count_q;
	logic [CntW-1:0]            n_act;
	logic [AddrW-1:0]           m_q;      // tap being issued, counts down
	logic [AddrW-1:0]           rd_addr;
	logic                       use_q;
	logic                       drain_q;
	logic signed [15:0]         sample_q;
	logic                       blk_q;

	// storage: entries without a valid bit read as zero
	logic signed [15:0]         dly_mem [MaxTaps];
	logic signed [31:0]         coef_mem [MaxTaps];
	logic [MaxTaps-1:0]         dly_vld_q;
	logic [MaxTaps-1:0]         coef_vld_q;

	// stage 1: read data back from memories
	logic                       vld_s1;
	logic                       m0_s1;
	logic                       use_s1;
	logic [AddrW-1:0]           waddr_s1;
	logic signed [15:0]         dly_rd_s1;
	logic                       dly_rv_s1;
	logic signed [31:0]         coef_rd_s1;
	logic                       coef_rv_s1;

	logic signed [15:0]         dly_old;
	logic signed [15:0]         dly_wdata;
	logic signed [31:0]         coef_mul;

	logic                       req_acc;
	logic                       is_sample;
	logic                       coef_wr;
	logic                       clr;
	logic                       rsp_load;

	fir_pkg::mac_ctl_t          mac_ctl;
	logic signed [15:0]         mac_res;

	logic                       rsp_valid_q;
	logic signed [15:0]         rsp_data_q;
	logic                       rsp_blk_q;

	// ---------------- request decode ----------------
	assign req_ch.ready = (state_q == S_IDLE);
	assign req_acc      = req_ch.valid && req_ch.ready;
	assign is_sample    = req_acc && (req_ch.req_type == fir_pkg::REQ_SAMPLE);
	assign clr          = req_acc && (req_ch.req_type == fir_pkg::REQ_CLEAR);
	assign coef_wr      = req_acc && (req_ch.req_type == fir_pkg::REQ_COEF)
		&& (CmpW'(req_ch.coef_index) < CmpW'(MaxTaps));

	// tap count saturates at the delay line depth
	always_comb begin
		if (CmpW'(tap_count_q) > CmpW'(MaxTaps)) begin
			n_act = CntW'(MaxTaps);
		end else begin
			n_act = CntW'(tap_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fir_pkg::TAP_COUNT_RST;
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	// ---------------- sequencer ----------------
	// Taps are visited from n-1 down to 0. Tap m reads old slot m-1 and writes
	// it to slot m in stage 1, so the shift and the MAC share one pass. Tap 0
	// uses the new sample. With zero taps, one pass still writes slot 0 but
	// its product is masked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_q     <= '0;
			use_q   <= 1'b0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (is_sample) begin
						state_q <= S_RUN;
						use_q   <= (n_act != '0);
						if (n_act == '0) begin
							m_q <= '0;
						end else begin
							m_q <= AddrW'(n_act - 1'b1);
						end
					end
				end
				S_RUN: begin
					if (m_q == '0) begin
						state_q <= S_DRAIN;
						drain_q <= 1'b0;
					end else begin
						m_q <= m_q - 1'b1;
					end
				end
				S_DRAIN: begin
					// product register, then accumulator
					if (drain_q) begin
						state_q <= S_FIN;
					end else begin
						drain_q <= 1'b1;
					end
				end
				S_FIN: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_sample) begin
			sample_q <= req_ch.sample_in;
			blk_q    <= req_ch.block_end;
		end
	end

	// ---------------- memories ----------------
	assign rd_addr = m_q - 1'b1;

	always_ff @(posedge clk) begin
		dly_rd_s1  <= dly_mem[rd_addr];
		dly_rv_s1  <= dly_vld_q[rd_addr];
		coef_rd_s1 <= coef_mem[m_q];
		coef_rv_s1 <= coef_vld_q[m_q];
		waddr_s1   <= m_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			m0_s1  <= 1'b0;
			use_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_RUN);
			m0_s1  <= (m_q == '0);
			use_s1 <= use_q;
		end
	end

	assign dly_old   = dly_rv_s1 ? dly_rd_s1 : '0;
	assign dly_wdata = m0_s1 ? sample_q : dly_old;
	assign coef_mul  = coef_rv_s1 ? coef_rd_s1 : '0;

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			dly_mem[waddr_s1] <= dly_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (coef_wr) begin
			coef_mem[AddrW'(req_ch.coef_index)] <= req_ch.coef_value;
		end
	end

	// clear drops every valid bit at once; it is only taken while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_vld_q  <= '0;
			coef_vld_q <= '0;
		end else if (clr) begin
			dly_vld_q  <= '0;
			coef_vld_q <= '0;
		end else begin
			if (vld_s1) begin
				dly_vld_q[waddr_s1] <= 1'b1;
			end
			if (coef_wr) begin
				coef_vld_q[AddrW'(req_ch.coef_index)] <= 1'b1;
			end
		end
	end

	// ---------------- shared multiply-accumulate ----------------
	assign mac_ctl.clr    = is_sample;
	assign mac_ctl.mul_en = vld_s1 && use_s1;

	fir_mac #(
		.MaxTaps (MaxTaps)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef_mul),
		.dly    (dly_wdata),
		.result (mac_res)
	);

	// ---------------- output register ----------------
	assign rsp_load = (state_q == S_FIN) && (!rsp_valid_q || rsp_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_data_q <= mac_res;
			rsp_blk_q  <= blk_q;
		end
	end

	assign rsp_ch.valid         = rsp_valid_q;
	assign rsp_ch.sample_out    = rsp_data_q;
	assign rsp_ch.block_end_out = rsp_blk_q;

	// ---------------- assertions ----------------
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish state");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && !$past(state_q == S_RUN) |-> !vld_s1)
		else $error("delay write pending while idle");

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		is_sample |=> (state_q == S_RUN))
		else $error("accepted sample did not start the pass");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && rsp_valid_q && !rsp_ch.ready |=> (state_q == S_FIN))
		else $error("finished result overran a waiting result");

endmodule

// ----- rtl/fir_mac.sv -----
module fir_mac #(
	parameter int MaxTaps = fir_pkg::MAX_TAP_COUNT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fir_pkg::mac_ctl_t                   ctl,
	input  logic signed [fir_pkg::COEF_W-1:0]   coef,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] dly,
	output logic signed [fir_pkg::SAMPLE_W-1:0] result
);

	localparam int AccW = fir_pkg::PROD_W + $clog2(MaxTaps) + 1;
	localparam int ResW = AccW - fir_pkg::FRAC_SHIFT;

	logic signed [fir_pkg::PROD_W-1:0] prod_s2;
	logic                              mul_vld_s2;
	logic signed [AccW-1:0]            acc_q;
	logic signed [ResW-1:0]            floor_res;
	logic [ResW-fir_pkg::SAMPLE_W:0]   hi_bits;

	always_ff @(posedge clk) begin
		prod_s2 <= coef * dly;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s2 <= 1'b0;
		end else begin
			mul_vld_s2 <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (mul_vld_s2) begin
			acc_q <= acc_q + AccW'(prod_s2);
		end
	end

	// arithmetic right shift = floor toward minus infinity
	assign floor_res = acc_q[AccW-1:fir_pkg::FRAC_SHIFT];
	assign hi_bits   = floor_res[ResW-1:fir_pkg::SAMPLE_W-1];

	always_comb begin
		if (&hi_bits || ~|hi_bits) begin
			result = floor_res[fir_pkg::SAMPLE_W-1:0];
		end else if (floor_res[ResW-1]) begin
			result = 16'sh8000;
		end else begin
			result = 16'sh7FFF;
		end
	end

endmodule
